// ===== design/cws_pkg.sv =====
package cws_pkg;

  localparam int COORD_BITS      = 14;
  localparam int RATIO_FRAC_BITS = 12;
  localparam int PERCENT         = 100;

  localparam int RATE_W      = 7;
  localparam int RATIO_W     = 16;
  localparam int DIM_W       = 13;
  localparam int OUT_COORD_W = 12;
  localparam int NUM_EDGES   = 4;
  localparam int EDGE_IDX_W  = 2;

  // edge step datapath
  localparam int DIST_W      = COORD_BITS + 1;
  localparam int PROD_X_W    = RATE_W + COORD_BITS;
  localparam int RECIP_SHIFT = PROD_X_W + 7;
  localparam longint RECIP_MUL =
    ((longint'(1) << RECIP_SHIFT) + longint'(PERCENT) - 1) / longint'(PERCENT);
  localparam int RECIP_W     = RECIP_SHIFT - 6;
  localparam int QUOT_W      = PROD_X_W - 6;
  localparam int EDGE_W      = COORD_BITS + 3;

  // size / placement datapath
  localparam int WH_W     = EDGE_W + 1;
  localparam int SIZE_W   = WH_W + (RATIO_W - RATIO_FRAC_BITS) + 1;
  localparam int PLACE_W  = SIZE_W + 2;
  localparam int CENTER_W = COORD_BITS + 1;

  // shared multiplier
  localparam int MUL_A_W = PROD_X_W + 1;
  localparam int MUL_B_W = ((RECIP_W > RATIO_W) ? RECIP_W : RATIO_W) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int IN_DATA_W  = ((NUM_EDGES * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_EDGES * OUT_COORD_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_EXPAND_RATE      = 3'd0,
    REG_CONTRACT_RATE    = 3'd1,
    REG_ASPECT_Q         = 3'd2,
    REG_INVERSE_ASPECT_Q = 3'd3,
    REG_FRAME_WIDTH      = 3'd4,
    REG_FRAME_HEIGHT     = 3'd5,
    REG_MAX_CROP_WIDTH   = 3'd6,
    REG_MAX_CROP_HEIGHT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0]  expand_rate;
    logic [RATE_W-1:0]  contract_rate;
    logic [RATIO_W-1:0] aspect_q;
    logic [RATIO_W-1:0] inverse_aspect_q;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [DIM_W-1:0]   max_crop_width;
    logic [DIM_W-1:0]   max_crop_height;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_RECIP,
    OP_UPDATE,
    OP_SIZE,
    OP_MUL_W,
    OP_MUL_H,
    OP_MUL_CAP,
    OP_CAP_W,
    OP_CAP_H,
    OP_PLACE_A,
    OP_PLACE_B,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_RECIP,
    ST_UPDATE,
    ST_SIZE,
    ST_MUL_W,
    ST_MUL_H,
    ST_MUL_CAP,
    ST_CAP_W,
    ST_CAP_H,
    ST_PLACE_A,
    ST_PLACE_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                   op;
    logic [EDGE_IDX_W-1:0] idx;
  } cmd_t;

endpackage

// ===== design/cws_regs.sv =====
module cws_regs
  import cws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t sel;

  assign wr_en = psel & penable & pwrite;
  assign sel   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expand_rate      <= RATE_W'(30);
      cfg_r.contract_rate    <= RATE_W'(5);
      cfg_r.aspect_q         <= RATIO_W'(7282);
      cfg_r.inverse_aspect_q <= RATIO_W'(2304);
      cfg_r.frame_width      <= DIM_W'(640);
      cfg_r.frame_height     <= DIM_W'(480);
      cfg_r.max_crop_width   <= DIM_W'(640);
      cfg_r.max_crop_height  <= DIM_W'(360);
    end else if (wr_en) begin
      unique case (sel)
        REG_EXPAND_RATE:      cfg_r.expand_rate      <= pwdata[RATE_W-1:0];
        REG_CONTRACT_RATE:    cfg_r.contract_rate    <= pwdata[RATE_W-1:0];
        REG_ASPECT_Q:         cfg_r.aspect_q         <= pwdata[RATIO_W-1:0];
        REG_INVERSE_ASPECT_Q: cfg_r.inverse_aspect_q <= pwdata[RATIO_W-1:0];
        REG_FRAME_WIDTH:      cfg_r.frame_width      <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT:     cfg_r.frame_height     <= pwdata[DIM_W-1:0];
        REG_MAX_CROP_WIDTH:   cfg_r.max_crop_width   <= pwdata[DIM_W-1:0];
        REG_MAX_CROP_HEIGHT:  cfg_r.max_crop_height  <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_EXPAND_RATE:      prdata = CFG_DATA_W'(cfg_r.expand_rate);
      REG_CONTRACT_RATE:    prdata = CFG_DATA_W'(cfg_r.contract_rate);
      REG_ASPECT_Q:         prdata = CFG_DATA_W'(cfg_r.aspect_q);
      REG_INVERSE_ASPECT_Q: prdata = CFG_DATA_W'(cfg_r.inverse_aspect_q);
      REG_FRAME_WIDTH:      prdata = CFG_DATA_W'(cfg_r.frame_width);
      REG_FRAME_HEIGHT:     prdata = CFG_DATA_W'(cfg_r.frame_height);
      REG_MAX_CROP_WIDTH:   prdata = CFG_DATA_W'(cfg_r.max_crop_width);
      REG_MAX_CROP_HEIGHT:  prdata = CFG_DATA_W'(cfg_r.max_crop_height);
    endcase
  end

endmodule

// ===== design/cws_ctrl.sv =====
module cws_ctrl
  import cws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  state_t                state_r, state_nxt;
  logic [EDGE_IDX_W-1:0] idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;
  logic                  last_edge;

  assign out_free  = !out_valid_r || out_tready;
  assign last_edge = (idx_r == EDGE_IDX_W'(NUM_EDGES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_STEP;
          idx_nxt   = '0;
        end
      end
      ST_STEP:   state_nxt = ST_RECIP;
      ST_RECIP:  state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (last_edge) begin
          state_nxt = ST_SIZE;
        end else begin
          state_nxt = ST_STEP;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_SIZE:    state_nxt = ST_MUL_W;
      ST_MUL_W:   state_nxt = ST_MUL_H;
      ST_MUL_H:   state_nxt = ST_MUL_CAP;
      ST_MUL_CAP: state_nxt = ST_CAP_W;
      ST_CAP_W:   state_nxt = ST_CAP_H;
      ST_CAP_H:   state_nxt = ST_PLACE_A;
      ST_PLACE_A: state_nxt = ST_PLACE_B;
      ST_PLACE_B: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    cmd.idx    = idx_r;
    unique case (state_r)
      ST_IDLE:    cmd.op = in_tvalid ? OP_LOAD : OP_NONE;
      ST_STEP:    cmd.op = OP_STEP;
      ST_RECIP:   cmd.op = OP_RECIP;
      ST_UPDATE:  cmd.op = OP_UPDATE;
      ST_SIZE:    cmd.op = OP_SIZE;
      ST_MUL_W:   cmd.op = OP_MUL_W;
      ST_MUL_H:   cmd.op = OP_MUL_H;
      ST_MUL_CAP: cmd.op = OP_MUL_CAP;
      ST_CAP_W:   cmd.op = OP_CAP_W;
      ST_CAP_H:   cmd.op = OP_CAP_H;
      ST_PLACE_A: cmd.op = OP_PLACE_A;
      ST_PLACE_B: cmd.op = OP_PLACE_B;
      ST_DONE:    cmd.op = out_free ? OP_EMIT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

// ===== design/cws_datapath.sv =====
module cws_datapath
  import cws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  cfg_t                  cfg,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam logic signed [PLACE_W-1:0] P_ONE = PLACE_W'(1);
  localparam logic signed [WH_W-1:0]    WH_ONE = WH_W'(1);

  function automatic logic signed [SIZE_W-1:0] mulq(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] adj;
    // bias negatives so the shift truncates toward zero
    bias = p[PROD_W-1] ? $signed(PROD_W'((1 << RATIO_FRAC_BITS) - 1)) : $signed(PROD_W'(0));
    adj  = p + bias;
    return SIZE_W'(adj >>> RATIO_FRAC_BITS);
  endfunction

  function automatic logic signed [PLACE_W-1:0] half_tz(input logic signed [PLACE_W-1:0] v);
    logic signed [PLACE_W-1:0] adj;
    adj = v + $signed(PLACE_W'(v[PLACE_W-1]));
    return adj >>> 1;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [PLACE_W-1:0] v);
    logic signed [PLACE_W-1:0] hi;
    logic signed [PLACE_W-1:0] lo;
    hi = PLACE_W'((1 << (COORD_BITS - 1)) - 1);
    lo = -PLACE_W'(1 << (COORD_BITS - 1));
    priority if (v > hi) return hi[COORD_BITS-1:0];
    else if (v < lo)     return lo[COORD_BITS-1:0];
    else                 return v[COORD_BITS-1:0];
  endfunction

  function automatic logic [OUT_COORD_W-1:0] out_sat(input logic signed [PLACE_W-1:0] v);
    logic signed [PLACE_W-1:0] hi;
    hi = PLACE_W'((1 << OUT_COORD_W) - 1);
    priority if (v < 0) return '0;
    else if (v > hi)    return '1;
    else                return v[OUT_COORD_W-1:0];
  endfunction

  logic signed [COORD_BITS-1:0] tgt_r  [NUM_EDGES];
  logic signed [COORD_BITS-1:0] base_r [NUM_EDGES];
  logic signed [COORD_BITS-1:0] last_r [NUM_EDGES];
  logic                         last_valid_r;
  logic signed [EDGE_W-1:0]     edge_r [NUM_EDGES];
  logic                         sub_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [WH_W-1:0]       w_r, h_r;
  logic signed [SIZE_W-1:0]     pw_r, ph_r;
  logic signed [CENTER_W-1:0]   cx_r, cy_r;
  logic signed [PLACE_W-1:0]    ax_r, ay_r;
  logic [OUT_COORD_W-1:0]       res_r [NUM_EDGES];
  logic [OUT_DATA_W-1:0]        out_r;

  logic signed [COORD_BITS-1:0] t_sel, l_sel;
  logic signed [DIST_W-1:0]     gap;
  logic [DIST_W-1:0]            mag;
  logic                         is_lo, outside;
  logic [RATE_W-1:0]            rate;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic [QUOT_W-1:0]            quot;
  logic signed [EDGE_W-1:0]     l_ext, q_ext, edge_new;
  logic signed [SIZE_W-1:0]     prod_q;
  logic signed [SIZE_W-1:0]     max_w, max_h;
  logic signed [PLACE_W-1:0]    cx_full, cy_full;
  logic signed [PLACE_W-1:0]    ax_new, ay_new;
  logic signed [PLACE_W-1:0]    bx_sum, by_sum, bx, by, lox, loy;
  logic signed [PLACE_W-1:0]    lim_x, lim_y, pw_ext, ph_ext;
  logic signed [PLACE_W-1:0]    base_right, base_bottom;

  assign t_sel   = tgt_r[cmd.idx];
  assign l_sel   = base_r[cmd.idx];
  assign gap     = DIST_W'(t_sel) - DIST_W'(l_sel);
  assign mag     = gap[DIST_W-1] ? -gap : gap;
  // left and top move outward when the target is below, right and bottom when above
  assign is_lo   = ~cmd.idx[1];
  assign outside = is_lo ? gap[DIST_W-1] : (!gap[DIST_W-1] && (gap != '0));
  assign rate    = outside ? cfg.expand_rate : cfg.contract_rate;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_STEP: begin
        mul_a = $signed(MUL_A_W'(mag));
        mul_b = $signed(MUL_B_W'(rate));
      end
      OP_RECIP: begin
        mul_a = $signed(MUL_A_W'(prod_r[PROD_X_W-1:0]));
        mul_b = $signed(MUL_B_W'(RECIP_MUL));
      end
      OP_MUL_W: begin
        mul_a = MUL_A_W'(h_r);
        mul_b = $signed(MUL_B_W'(cfg.aspect_q));
      end
      OP_MUL_H: begin
        mul_a = MUL_A_W'(w_r);
        mul_b = $signed(MUL_B_W'(cfg.inverse_aspect_q));
      end
      OP_MUL_CAP: begin
        mul_a = $signed(MUL_A_W'(cfg.max_crop_width));
        mul_b = $signed(MUL_B_W'(cfg.inverse_aspect_q));
      end
      OP_CAP_W: begin
        mul_a = $signed(MUL_A_W'(cfg.max_crop_height));
        mul_b = $signed(MUL_B_W'(cfg.aspect_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // reciprocal is wide enough that the truncated product is the exact quotient
  assign quot     = prod_r[RECIP_SHIFT +: QUOT_W];
  assign l_ext    = EDGE_W'(l_sel);
  assign q_ext    = $signed(EDGE_W'(quot));
  assign edge_new = sub_r ? (l_ext - q_ext) : (l_ext + q_ext);

  assign prod_q = mulq(prod_r);
  assign max_w  = $signed(SIZE_W'(cfg.max_crop_width));
  assign max_h  = $signed(SIZE_W'(cfg.max_crop_height));

  assign cx_full = half_tz(half_tz(PLACE_W'(tgt_r[0]) + PLACE_W'(tgt_r[2]))
                         + half_tz(PLACE_W'(base_r[0]) + PLACE_W'(base_r[2])));
  assign cy_full = half_tz(half_tz(PLACE_W'(tgt_r[1]) + PLACE_W'(tgt_r[3]))
                         + half_tz(PLACE_W'(base_r[1]) + PLACE_W'(base_r[3])));

  assign pw_ext = PLACE_W'(pw_r);
  assign ph_ext = PLACE_W'(ph_r);
  assign lim_x  = $signed(PLACE_W'(cfg.frame_width));
  assign lim_y  = $signed(PLACE_W'(cfg.frame_height));

  always_comb begin
    ax_new = PLACE_W'(cx_r) - half_tz(pw_ext);
    ay_new = PLACE_W'(cy_r) - half_tz(ph_ext);
    if (ax_new < 0) ax_new = '0;
    if (ay_new < 0) ay_new = '0;
  end

  // clip the far edge, then the near edge follows it back by the full size
  always_comb begin
    bx_sum = pw_ext + ax_r;
    by_sum = ph_ext + ay_r;
    bx     = (bx_sum > lim_x) ? lim_x : bx_sum;
    by     = (by_sum > lim_y) ? lim_y : by_sum;
    lox    = bx - pw_ext + P_ONE;
    loy    = by - ph_ext + P_ONE;
  end

  assign base_right  = lim_x - P_ONE;
  assign base_bottom = lim_y - P_ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      last_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < NUM_EDGES; i++) begin
          tgt_r[i] <= $signed(in_data[i*COORD_BITS +: COORD_BITS]);
        end
        if (last_valid_r) begin
          for (int i = 0; i < NUM_EDGES; i++) begin
            base_r[i] <= last_r[i];
          end
        end else begin
          base_r[0] <= '0;
          base_r[1] <= '0;
          base_r[2] <= sat_coord(base_right);
          base_r[3] <= sat_coord(base_bottom);
        end
      end
      OP_STEP: begin
        prod_r <= mul_p;
        sub_r  <= (is_lo == outside);
      end
      OP_RECIP: prod_r <= mul_p;
      OP_UPDATE: edge_r[cmd.idx] <= edge_new;
      OP_SIZE: begin
        w_r  <= WH_W'(edge_r[2]) - WH_W'(edge_r[0]) + WH_ONE;
        h_r  <= WH_W'(edge_r[3]) - WH_W'(edge_r[1]) + WH_ONE;
        cx_r <= CENTER_W'(cx_full);
        cy_r <= CENTER_W'(cy_full);
      end
      OP_MUL_W: prod_r <= mul_p;
      OP_MUL_H: begin
        pw_r   <= (SIZE_W'(w_r) > prod_q) ? SIZE_W'(w_r) : prod_q;
        prod_r <= mul_p;
      end
      OP_MUL_CAP: begin
        ph_r   <= (SIZE_W'(h_r) > prod_q) ? SIZE_W'(h_r) : prod_q;
        prod_r <= mul_p;
      end
      OP_CAP_W: begin
        if (pw_r > max_w) begin
          pw_r <= max_w;
          ph_r <= prod_q;
        end
        prod_r <= mul_p;
      end
      OP_CAP_H: begin
        if (ph_r > max_h) begin
          ph_r <= max_h;
          pw_r <= prod_q;
        end
      end
      OP_PLACE_A: begin
        ax_r <= ax_new;
        ay_r <= ay_new;
      end
      OP_PLACE_B: begin
        last_r[0] <= sat_coord(lox);
        last_r[1] <= sat_coord(loy);
        last_r[2] <= sat_coord(bx);
        last_r[3] <= sat_coord(by);
        res_r[0]  <= out_sat(lox);
        res_r[1]  <= out_sat(loy);
        res_r[2]  <= out_sat(bx);
        res_r[3]  <= out_sat(by);
      end
      OP_EMIT: out_r <= OUT_DATA_W'({res_r[3], res_r[2], res_r[1], res_r[0]});
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

// ===== design/crop_window_smoother_unit.sv =====
// Crop window smoother.
// in_*  : one target rectangle per video frame (inclusive edges, signed).
// out_* : the smoothed crop rectangle, edges saturated to 0..4095.
// cfg_* : APB register port, registers at byte address 4*i, pready tied high;
//         write registers only while no transaction is in flight.
// Each transaction runs through a sequencer that drives one shared multiplier:
// two products per edge (rate times distance, then the reciprocal of 100),
// then the aspect and cap products, then the placement of the window.
// out_tvalid and in_tready rise at the same edge, so the next input
// transaction is accepted only once the previous one is through: each
// edge takes a step, a reciprocal and an update state, followed by the
// sizing and placement states, the output state and the accept state.
// The result sits in an output register; if the receiver stalls, the next
// transaction is still accepted and computed, and only waits in its final
// cycle until the output register is free.
// Reset restores the register defaults and marks the stored rectangle
// unused, so the first transaction starts from the full frame.
module crop_window_smoother_unit
  import cws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // target_left, target_top, target_right, target_bottom
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // crop_left, crop_top, crop_right, crop_bottom
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;

  assign cfg_pready = 1'b1;

  cws_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  cws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cws_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cws_pkg::*;

  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LINES  = 100;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] bottom;
    logic [OUT_COORD_W-1:0] right;
    logic [OUT_COORD_W-1:0] top;
    logic [OUT_COORD_W-1:0] left;
  } crop_rect_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // target_left, target_top, target_right, target_bottom
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // crop_left, crop_top, crop_right, crop_bottom
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  crop_window_smoother_unit u_dut (.*);

  always #6 clk = ~clk;

  // register mirror and stored crop window of the predictor
  cfg_t   crop_cfg = '{expand_rate: 30, contract_rate: 5, aspect_q: 7282,
                       inverse_aspect_q: 2304, frame_width: 640, frame_height: 480,
                       max_crop_width: 640, max_crop_height: 360};
  longint held_left, held_top, held_right, held_bottom;
  bit     held_valid;

  crop_rect_t expected_crops[$];
  int         error_count;
  int         cycle_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  string      side_names[NUM_EDGES] = '{"left", "top", "right", "bottom"};

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp_coord(longint v);
    longint hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    longint lo = -(longint'(1) << (COORD_BITS - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // signed value times unsigned Q4.12, truncated toward zero
  function automatic longint scale_q(longint v, longint q);
    longint p = v * q;
    if (p >= 0) return p >>> RATIO_FRAC_BITS;
    return -((-p) >>> RATIO_FRAC_BITS);
  endfunction

  function automatic longint edge_step(longint rate, longint gap);
    if (gap < 0) gap = -gap;
    return (rate * gap) / PERCENT;
  endfunction

  function automatic logic [OUT_COORD_W-1:0] clip_out(longint v);
    return OUT_COORD_W'(v < 0 ? 0 : (v > 4095 ? 4095 : v));
  endfunction

  function automatic void fit_span(input longint centre, input longint size,
                                   input longint limit, output longint lo,
                                   output longint hi);
    longint a, b;
    a = centre - size / 2;
    if (a < 0) a = 0;
    b = size + a;
    if (b > limit) b = limit;
    lo = a - (size - (b - a + 1));
    hi = b;
  endfunction

  function automatic longint coord_of(logic [IN_DATA_W-1:0] v, int i);
    return longint'($signed(v[i*COORD_BITS +: COORD_BITS]));
  endfunction

  function automatic crop_rect_t advance_crop(input logic [IN_DATA_W-1:0] target);
    longint tl, tt, tr, tb, ll, lt, lr, lb, nl, nt, nr, nb;
    longint w, h, pw, ph, cx, cy, er, cr, fw, fh, mw, mh, aq, iq;
    crop_rect_t rect;
    tl = coord_of(target, 0);
    tt = coord_of(target, 1);
    tr = coord_of(target, 2);
    tb = coord_of(target, 3);
    er = longint'(crop_cfg.expand_rate);
    cr = longint'(crop_cfg.contract_rate);
    aq = longint'(crop_cfg.aspect_q);
    iq = longint'(crop_cfg.inverse_aspect_q);
    fw = longint'(crop_cfg.frame_width);
    fh = longint'(crop_cfg.frame_height);
    mw = longint'(crop_cfg.max_crop_width);
    mh = longint'(crop_cfg.max_crop_height);
    if (!held_valid) begin
      held_left = 0;
      held_top = 0;
      held_right = clamp_coord(fw - 1);
      held_bottom = clamp_coord(fh - 1);
    end
    ll = held_left; lt = held_top; lr = held_right; lb = held_bottom;

    nl = tl < ll ? ll - edge_step(er, tl - ll) : ll + edge_step(cr, tl - ll);
    nt = tt < lt ? lt - edge_step(er, tt - lt) : lt + edge_step(cr, tt - lt);
    nr = tr > lr ? lr + edge_step(er, tr - lr) : lr - edge_step(cr, tr - lr);
    nb = tb > lb ? lb + edge_step(er, tb - lb) : lb - edge_step(cr, tb - lb);

    w = nr - nl + 1;
    h = nb - nt + 1;
    pw = scale_q(h, aq);
    if (w > pw) pw = w;
    ph = scale_q(w, iq);
    if (h > ph) ph = h;
    if (pw > mw) begin
      pw = mw;
      ph = scale_q(mw, iq);
    end
    if (ph > mh) begin
      ph = mh;
      pw = scale_q(mh, aq);
    end

    cx = ((tl + tr) / 2 + (ll + lr) / 2) / 2;
    cy = ((tt + tb) / 2 + (lt + lb) / 2) / 2;
    fit_span(cx, pw, fw, nl, nr);
    fit_span(cy, ph, fh, nt, nb);

    held_left = clamp_coord(nl);
    held_top = clamp_coord(nt);
    held_right = clamp_coord(nr);
    held_bottom = clamp_coord(nb);
    held_valid = 1'b1;

    rect.left = clip_out(nl);
    rect.top = clip_out(nt);
    rect.right = clip_out(nr);
    rect.bottom = clip_out(nb);
    return rect;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    if (error_count < REPORT_LINES) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    crop_rect_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[NUM_EDGES*OUT_COORD_W-1:0];
      if (expected_crops.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction pending", got));
      end else begin
        want = expected_crops.pop_front();
        for (int i = 0; i < NUM_EDGES; i++) begin
          if (got[i*OUT_COORD_W +: OUT_COORD_W] !== want[i*OUT_COORD_W +: OUT_COORD_W])
            report_mismatch($sformatf("crop_%s got %0d want %0d", side_names[i],
                            got[i*OUT_COORD_W +: OUT_COORD_W],
                            want[i*OUT_COORD_W +: OUT_COORD_W]));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crop_window_smoother_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic apb_access(input logic wr, input reg_idx_t idx,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_EXPAND_RATE:      return CFG_DATA_W'(crop_cfg.expand_rate);
      REG_CONTRACT_RATE:    return CFG_DATA_W'(crop_cfg.contract_rate);
      REG_ASPECT_Q:         return CFG_DATA_W'(crop_cfg.aspect_q);
      REG_INVERSE_ASPECT_Q: return CFG_DATA_W'(crop_cfg.inverse_aspect_q);
      REG_FRAME_WIDTH:      return CFG_DATA_W'(crop_cfg.frame_width);
      REG_FRAME_HEIGHT:     return CFG_DATA_W'(crop_cfg.frame_height);
      REG_MAX_CROP_WIDTH:   return CFG_DATA_W'(crop_cfg.max_crop_width);
      default:              return CFG_DATA_W'(crop_cfg.max_crop_height);
    endcase
  endfunction

  task automatic check_readback(input reg_idx_t idx);
    logic [CFG_DATA_W-1:0] rdata;
    apb_access(1'b0, idx, '0, rdata);
    if (rdata !== reg_value(idx))
      report_mismatch($sformatf("%s reads %h want %h", idx.name(), rdata, reg_value(idx)));
  endtask

  task automatic program_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] unused;
    case (idx)
      REG_EXPAND_RATE:      crop_cfg.expand_rate = value[RATE_W-1:0];
      REG_CONTRACT_RATE:    crop_cfg.contract_rate = value[RATE_W-1:0];
      REG_ASPECT_Q:         crop_cfg.aspect_q = value[RATIO_W-1:0];
      REG_INVERSE_ASPECT_Q: crop_cfg.inverse_aspect_q = value[RATIO_W-1:0];
      REG_FRAME_WIDTH:      crop_cfg.frame_width = value[DIM_W-1:0];
      REG_FRAME_HEIGHT:     crop_cfg.frame_height = value[DIM_W-1:0];
      REG_MAX_CROP_WIDTH:   crop_cfg.max_crop_width = value[DIM_W-1:0];
      default:              crop_cfg.max_crop_height = value[DIM_W-1:0];
    endcase
    apb_access(1'b1, idx, value, unused);
    check_readback(idx);
  endtask

  task automatic apply_settings(input cfg_t s);
    program_reg(REG_EXPAND_RATE, CFG_DATA_W'(s.expand_rate));
    program_reg(REG_CONTRACT_RATE, CFG_DATA_W'(s.contract_rate));
    program_reg(REG_ASPECT_Q, CFG_DATA_W'(s.aspect_q));
    program_reg(REG_INVERSE_ASPECT_Q, CFG_DATA_W'(s.inverse_aspect_q));
    program_reg(REG_FRAME_WIDTH, CFG_DATA_W'(s.frame_width));
    program_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(s.frame_height));
    program_reg(REG_MAX_CROP_WIDTH, CFG_DATA_W'(s.max_crop_width));
    program_reg(REG_MAX_CROP_HEIGHT, CFG_DATA_W'(s.max_crop_height));
  endtask

  // leaves in_tvalid high at the accepting edge; the caller either sends
  // again or calls end_stream in the same step
  task automatic push_target(input logic [IN_DATA_W-1:0] target);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= target;
    do @(posedge clk); while (!in_tready);
    expected_crops.push_back(advance_crop(target));
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    while (expected_crops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic logic [IN_DATA_W-1:0] pack_rect(int l, int t, int r, int b);
    return {COORD_BITS'(b), COORD_BITS'(r), COORD_BITS'(t), COORD_BITS'(l)};
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_target(input logic [IN_DATA_W-1:0] prev);
    int kind, fw, fh, x0, y0, w, h, tmp;
    int c[4];
    int corner_vals[8] = '{-8192, -4096, -1, 0, 1, 4095, 4096, 8191};
    kind = $urandom_range(99);
    fw = int'(crop_cfg.frame_width);
    fh = int'(crop_cfg.frame_height);
    if (kind < 40) begin
      // face drifting slowly from the previous frame
      for (int i = 0; i < NUM_EDGES; i++)
        c[i] = int'(coord_of(prev, i)) + int'($urandom_range(32)) - 16;
    end else if (kind < 70) begin
      x0 = int'($urandom_range(fw + 128)) - 64;
      y0 = int'($urandom_range(fh + 128)) - 64;
      w = int'($urandom_range(fw / 2 + 8));
      h = int'($urandom_range(fh / 2 + 8));
      c = '{x0, y0, x0 + w, y0 + h};
      if ($urandom_range(9) == 0) begin
        tmp = c[0]; c[0] = c[2]; c[2] = tmp;
      end
      if ($urandom_range(9) == 0) begin
        tmp = c[1]; c[1] = c[3]; c[3] = tmp;
      end
    end else if (kind < 85) begin
      return IN_DATA_W'({$urandom, $urandom});
    end else begin
      for (int i = 0; i < NUM_EDGES; i++)
        c[i] = $urandom_range(1) ? corner_vals[$urandom_range(7)]
                                 : int'($urandom_range(16383)) - 8192;
    end
    return pack_rect(c[0], c[1], c[2], c[3]);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.expand_rate = RATE_W'(($urandom_range(9) == 0) ? $urandom_range(127, 101)
                                                     : $urandom_range(100));
    s.contract_rate = RATE_W'(($urandom_range(9) == 0) ? $urandom_range(127, 101)
                                                       : $urandom_range(100));
    case ($urandom_range(3))
      0: begin s.aspect_q = 7282; s.inverse_aspect_q = 2304; end
      1: begin s.aspect_q = 5461; s.inverse_aspect_q = 3072; end
      2: begin s.aspect_q = 4096; s.inverse_aspect_q = 4096; end
      default: begin
        s.aspect_q = RATIO_W'($urandom_range(65535));
        s.inverse_aspect_q = RATIO_W'($urandom_range(65535));
      end
    endcase
    s.frame_width = DIM_W'(($urandom_range(19) == 0) ? 8191 : $urandom_range(4096, 16));
    s.frame_height = DIM_W'(($urandom_range(19) == 0) ? 8191 : $urandom_range(4096, 16));
    s.max_crop_width = DIM_W'(($urandom_range(9) == 0) ? $urandom_range(8191, 1)
                                                        : $urandom_range(s.frame_width, 1));
    s.max_crop_height = DIM_W'(($urandom_range(9) == 0) ? $urandom_range(8191, 1)
                                                         : $urandom_range(s.frame_height, 1));
    return s;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_register_defaults();
    reg_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      check_readback(idx);
      idx = idx.next();
    end
  endtask

  // first transaction starts from the full frame; then field extremes,
  // inverted rectangles and targets outside the frame
  task automatic test_directed_targets();
    tx_idle_pct = 30;
    rx_idle_pct = 76;
    push_target(pack_rect(100, 80, 300, 240));
    push_target(pack_rect(100, 80, 300, 240));
    push_target(pack_rect(0, 0, 639, 479));
    push_target(pack_rect(-8192, -8192, -8192, -8192));
    push_target(pack_rect(8191, 8191, 8191, 8191));
    push_target(pack_rect(-8192, -8192, 8191, 8191));
    push_target(pack_rect(8191, 8191, -8192, -8192));
    push_target(pack_rect(400, 300, 200, 100));
    push_target(pack_rect(0, 0, 0, 0));
    push_target(pack_rect(639, 479, 639, 479));
    push_target(pack_rect(-4096, -4096, 8191, 8191));
    push_target(pack_rect(320, 240, 320, 240));
    push_target(pack_rect(-100, -50, 50, 40));
    push_target(pack_rect(600, 440, 900, 700));
    push_target(pack_rect(10, 200, 630, 210));
    push_target(pack_rect(300, 5, 310, 475));
    push_target(pack_rect(-1, -1, 640, 480));
    push_target(pack_rect(4095, 4095, 4095, 4095));
    end_stream();
  endtask

  task automatic run_items(input int count);
    logic [IN_DATA_W-1:0] target;
    target = pack_rect(100, 100, 200, 200);
    repeat (count) begin
      target = make_target(target);
      push_target(target);
    end
    end_stream();
  endtask

  // rates of zero, 100 and above 100, ratios at both ends, tiny and huge frames
  task automatic test_config_extremes();
    cfg_t corners[4];
    corners[0] = '{expand_rate: 100, contract_rate: 100, aspect_q: 4096,
                   inverse_aspect_q: 4096, frame_width: 4096, frame_height: 4096,
                   max_crop_width: 4096, max_crop_height: 4096};
    corners[1] = '{expand_rate: 0, contract_rate: 0, aspect_q: 1,
                   inverse_aspect_q: 1, frame_width: 1, frame_height: 1,
                   max_crop_width: 1, max_crop_height: 1};
    corners[2] = '{expand_rate: 127, contract_rate: 127, aspect_q: 65535,
                   inverse_aspect_q: 65535, frame_width: 8191, frame_height: 8191,
                   max_crop_width: 8191, max_crop_height: 8191};
    corners[3] = '{expand_rate: 1, contract_rate: 99, aspect_q: 0,
                   inverse_aspect_q: 0, frame_width: 640, frame_height: 480,
                   max_crop_width: 320, max_crop_height: 240};
    tx_idle_pct = 30;
    rx_idle_pct = 76;
    foreach (corners[i]) begin
      apply_settings(corners[i]);
      run_items(40);
    end
  endtask

  task automatic test_random_traffic();
    int tx_pct[3] = '{30, 76, 0};
    int rx_pct[3] = '{76, 30, 0};
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = tx_pct[mode];
      rx_idle_pct = rx_pct[mode];
      repeat (4) begin
        apply_settings(random_settings());
        run_items(150);
      end
    end
  endtask

  initial begin
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_directed_targets();
    test_config_extremes();
    test_random_traffic();
    if (error_count == 0)
      $display("crop_window_smoother_unit regression: pass");
    else
      $display("crop_window_smoother_unit regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cws_pkg.sv
design/cws_regs.sv
design/cws_ctrl.sv
design/cws_datapath.sv
design/crop_window_smoother_unit.sv
sim/testbench.sv
